FILE: design/ssei_pkg.sv
package ssei_pkg;

   // Fixed field widths of the channels
   localparam int COORD_W  = 16;
   localparam int VALUE_W  = 64;
   localparam int INDEX_W  = 10;
   localparam int COUNT_W  = 11;
   localparam int STATUS_W = 3;

   // Response status codes
   localparam logic [STATUS_W-1:0] ST_APPENDED     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_INSERTED     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_OVERWRITTEN  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL         = 3'd3;
   localparam logic [STATUS_W-1:0] ST_READ_OK      = 3'd4;
   localparam logic [STATUS_W-1:0] ST_OUT_OF_RANGE = 3'd5;

   // Request kinds
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_READ   = 1'b1;

endpackage

FILE: design/ssei_req_if.sv
interface ssei_req_if import ssei_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               kind;
   logic [COORD_W-1:0] row;
   logic [COORD_W-1:0] column;
   logic [VALUE_W-1:0] value;
   logic [INDEX_W-1:0] read_index;

   modport source (output valid, kind, row, column, value, read_index, input ready);
   modport sink   (input valid, kind, row, column, value, read_index, output ready);
endinterface

FILE: design/ssei_rsp_if.sv
interface ssei_rsp_if import ssei_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [COORD_W-1:0]  entry_row;
   logic [COORD_W-1:0]  entry_column;
   logic [VALUE_W-1:0]  entry_value;
   logic [COUNT_W-1:0]  entry_count;

   modport source (output valid, status, entry_row, entry_column, entry_value, entry_count,
                   input ready);
   modport sink   (input valid, status, entry_row, entry_column, entry_value, entry_count,
                   output ready);
endinterface

FILE: design/ssei_ram.sv
module ssei_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/sorted_sparse_entry_insert.sv
// Sorted sparse entry table. Holds up to CAPACITY (row, column, value) entries in one
// single-port-write, single-port-read RAM, kept sorted row-major. A write transaction
// whose coordinates sort after the last entry is appended; one that matches existing
// coordinates overwrites the value; any other is inserted after shifting the tail up.
// A full table refuses new entries (status full) but still takes overwrites. A read
// transaction returns the entry at read_index with the current count. Every request
// yields exactly one response. Append, refused append and out-of-range read need no
// RAM read; an in-range read takes one RAM read. Overwrite and middle insert run a
// binary search for the first entry not below the key: each halving step reads the
// RAM (SRCH_RD) and compares (SRCH_CMP), then the candidate is read (CHK_RD, CHK).
// With N stored entries, an insert then moves the N-idx tail entries up at one per
// cycle through the RAM read/write ports, then writes the new entry. The RAM read
// latency sets the search step; the single write port sets the shift rate. A new
// request is taken while the previous response still waits in the output register.
// Coordinates are truncated to COORD_BITS (at most 16) before storing and comparing.
module sorted_sparse_entry_insert import ssei_pkg::*; #(
   parameter int CAPACITY   = 1024,
   parameter int COORD_BITS = 16
) (
   input logic        clock,
   input logic        reset,
   ssei_req_if.sink   req_chan,
   ssei_rsp_if.source rsp_chan
);

   // Stored coordinate width, entry word layout and counter widths
   localparam int CW   = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
   localparam int KW   = 2 * CW;
   localparam int WW   = KW + VALUE_W;
   localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNTW = $clog2(CAPACITY + 1);
   localparam int IXW  = (CNTW > INDEX_W) ? CNTW : INDEX_W;

   typedef enum logic [2:0] {
      IDLE,
      RD_DATA,
      SRCH_RD,
      SRCH_CMP,
      CHK_RD,
      CHK,
      SHIFT,
      FINISH
   } state_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [CW-1:0]       row;
      logic [CW-1:0]       column;
      logic [VALUE_W-1:0]  value;
   } res_type;

   state_type state_ff, state_in;

   logic [CNTW-1:0]    count_ff, count_in;
   logic [KW-1:0]      last_key_ff, last_key_in;   // coordinates of the final entry
   logic [KW-1:0]      key_ff, key_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [CNTW-1:0]    lo_ff, lo_in;
   logic [CNTW-1:0]    hi_ff, hi_in;
   logic [CNTW-1:0]    src_ff, src_in;
   logic [CNTW-1:0]    dst_ff, dst_in;
   logic               more_ff, more_in;           // shift reads still to issue
   logic               pend_ff, pend_in;           // shift read data on RAM output
   res_type            res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   res_type            rsp_ff, rsp_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic          mem_we, mem_re;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [WW-1:0] mem_wdata, mem_rdata;

   logic            req_accept;
   logic [KW-1:0]   req_key;
   logic [KW-1:0]   rd_key;
   logic [CNTW-1:0] mid;
   logic            full;

   ssei_ram #(
      .WIDTH (WW),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign req_chan.ready = (state_ff == IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign req_key        = {req_chan.row[CW-1:0], req_chan.column[CW-1:0]};
   assign rd_key         = mem_rdata[WW-1:VALUE_W];
   assign mid            = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign full           = (count_ff == CNTW'(CAPACITY));

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      last_key_in  = last_key_ff;
      key_in       = key_ff;
      value_in     = value_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      more_in      = more_ff;
      pend_in      = pend_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_count_in = rsp_count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      mem_we       = 1'b0;
      mem_waddr    = lo_ff[AW-1:0];
      mem_wdata    = {key_ff, value_ff};
      mem_re       = 1'b0;
      mem_raddr    = mid[AW-1:0];

      case (state_ff)
         IDLE: begin
            if (req_accept) begin
               key_in   = req_key;
               value_in = req_chan.value;
               res_in   = '0;
               if (req_chan.kind == KIND_READ) begin
                  if (IXW'(req_chan.read_index) < IXW'(count_ff)) begin
                     mem_re    = 1'b1;
                     mem_raddr = AW'(req_chan.read_index);
                     state_in  = RD_DATA;
                  end else begin
                     res_in.status = ST_OUT_OF_RANGE;
                     state_in      = FINISH;
                  end
               end else if (count_ff == '0 || req_key > last_key_ff) begin
                  // sorts after the tail: append, or refuse when full, without searching
                  if (full) begin
                     res_in.status = ST_FULL;
                  end else begin
                     mem_we        = 1'b1;
                     mem_waddr     = count_ff[AW-1:0];
                     mem_wdata     = {req_key, req_chan.value};
                     count_in      = count_ff + 1'b1;
                     last_key_in   = req_key;
                     res_in.status = ST_APPENDED;
                  end
                  state_in = FINISH;
               end else begin
                  lo_in    = '0;
                  hi_in    = count_ff;
                  state_in = SRCH_RD;
               end
            end
         end

         RD_DATA: begin
            res_in.status = ST_READ_OK;
            res_in.row    = mem_rdata[WW-1:WW-CW];
            res_in.column = mem_rdata[VALUE_W+CW-1:VALUE_W];
            res_in.value  = mem_rdata[VALUE_W-1:0];
            state_in      = FINISH;
         end

         SRCH_RD: begin
            mem_re   = 1'b1;
            state_in = SRCH_CMP;
         end

         SRCH_CMP: begin
            // lower bound on the concatenated key = row-major order
            if (rd_key < key_ff) begin
               lo_in = mid + 1'b1;
            end else begin
               hi_in = mid;
            end
            state_in = (lo_in == hi_in) ? CHK_RD : SRCH_RD;
         end

         CHK_RD: begin
            mem_re    = 1'b1;
            mem_raddr = lo_ff[AW-1:0];
            state_in  = CHK;
         end

         CHK: begin
            if (rd_key == key_ff) begin
               mem_we        = 1'b1;
               res_in.status = ST_OVERWRITTEN;
               state_in      = FINISH;
            end else if (full) begin
               res_in.status = ST_FULL;
               state_in      = FINISH;
            end else begin
               src_in   = count_ff - 1'b1;
               dst_in   = count_ff;
               more_in  = 1'b1;
               pend_in  = 1'b0;
               state_in = SHIFT;
            end
         end

         SHIFT: begin
            // read src, write its data at src+1 in the following cycle from the RAM output
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = dst_ff[AW-1:0];
               mem_wdata = mem_rdata;
               dst_in    = dst_ff - 1'b1;
            end
            if (more_ff) begin
               mem_re    = 1'b1;
               mem_raddr = src_ff[AW-1:0];
               src_in    = src_ff - 1'b1;
               more_in   = (src_ff != lo_ff);
            end
            pend_in = more_ff;
            if (!more_ff && !pend_ff) begin
               mem_we        = 1'b1;
               count_in      = count_ff + 1'b1;
               res_in.status = ST_INSERTED;
               state_in      = FINISH;
            end
         end

         FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_in       = res_ff;
               rsp_count_in = COUNT_W'(count_ff);
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end
         end

         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         more_ff      <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         more_ff      <= more_in;
         pend_ff      <= pend_in;
      end
      last_key_ff  <= last_key_in;
      key_ff       <= key_in;
      value_ff     <= value_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      src_ff       <= src_in;
      dst_ff       <= dst_in;
      res_ff       <= res_in;
      rsp_ff       <= rsp_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_ff.status;
   assign rsp_chan.entry_row    = COORD_W'(rsp_ff.row);
   assign rsp_chan.entry_column = COORD_W'(rsp_ff.column);
   assign rsp_chan.entry_value  = rsp_ff.value;
   assign rsp_chan.entry_count  = rsp_count_ff;

   // Table never holds more than its capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(CAPACITY))
      else $error("entry count above capacity");

   // Count moves only by single increments
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && count_ff != $past(count_ff)) |-> (count_ff == $past(count_ff) + 1'b1))
      else $error("entry count changed by other than one");

   // Never read and write the same entry in one cycle
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
      else $error("RAM read and write collide on one entry");

   // Search window stays non-empty while searching
   a_search_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SRCH_RD || state_ff == SRCH_CMP) |-> (lo_ff < hi_ff))
      else $error("search window empty during search");

endmodule

FILE: tb/tb.sv
module tb;
   import ssei_pkg::*;

   // Geometry the block is built with; the table model below follows it.
   localparam int TABLE_DEPTH = 1024;
   localparam int COORD_BITS  = 16;
   localparam logic [COORD_W-1:0] COORD_MASK = {COORD_W{1'b1}} >> (COORD_W - COORD_BITS);

   // Worst correct gap between two accepted transactions is a middle insert into a
   // nearly full table plus a stall; this leaves room.
   localparam int QUIET_LIMIT  = 8000;
   localparam int DRAIN_CYCLES = 50;
   localparam int MIX_ITEMS    = 1050;
   localparam int FULL_ITEMS   = 120;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COORD_W-1:0]  row;
      logic [COORD_W-1:0]  column;
      logic [VALUE_W-1:0]  value;
      logic [COUNT_W-1:0]  count;
   } outcome_type;

   logic clock;
   logic reset;

   ssei_req_if req_chan ();
   ssei_rsp_if rsp_chan ();

   sorted_sparse_entry_insert #(
      .CAPACITY   (TABLE_DEPTH),
      .COORD_BITS (COORD_BITS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Shadow copy of the sorted entry table, updated as each request is accepted.
   logic [COORD_W-1:0] tbl_row [TABLE_DEPTH];
   logic [COORD_W-1:0] tbl_col [TABLE_DEPTH];
   logic [VALUE_W-1:0] tbl_val [TABLE_DEPTH];
   int                 tbl_count = 0;

   outcome_type pending_outcomes[$];
   int          fail_count   = 0;
   int          quiet_cycles = 0;
   bit          idle_enable  = 1'b1;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Apply one request to the shadow table and return the response it must produce.
   // The table is sorted on the packed {row, column} key, so the first slot whose key
   // is not below the new one is where an overwrite or insert lands; no such slot
   // means the key sorts after the last entry and the transaction is an append.
   function automatic outcome_type update_table(input logic kind,
                                                input logic [COORD_W-1:0] row_in,
                                                input logic [COORD_W-1:0] col_in,
                                                input logic [VALUE_W-1:0] val_in,
                                                input logic [INDEX_W-1:0] index_in);
      outcome_type        res;
      logic [COORD_W-1:0] r;
      logic [COORD_W-1:0] c;
      int                 pos;
      res = '0;
      r   = row_in & COORD_MASK;
      c   = col_in & COORD_MASK;
      pos = 0;
      if (kind == KIND_READ) begin
         if (index_in < tbl_count) begin
            res.status = ST_READ_OK;
            res.row    = tbl_row[index_in];
            res.column = tbl_col[index_in];
            res.value  = tbl_val[index_in];
         end else begin
            res.status = ST_OUT_OF_RANGE;
         end
      end else begin
         while (pos < tbl_count && {tbl_row[pos], tbl_col[pos]} < {r, c})
            pos++;
         if (pos < tbl_count && tbl_row[pos] == r && tbl_col[pos] == c) begin
            // same coordinates: overwrite, allowed even when the table is full
            tbl_val[pos] = val_in;
            res.status   = ST_OVERWRITTEN;
         end else if (tbl_count >= TABLE_DEPTH) begin
            res.status = ST_FULL;
         end else begin
            res.status = (pos == tbl_count) ? ST_APPENDED : ST_INSERTED;
            for (int k = tbl_count; k > pos; k--) begin
               tbl_row[k] = tbl_row[k-1];
               tbl_col[k] = tbl_col[k-1];
               tbl_val[k] = tbl_val[k-1];
            end
            tbl_row[pos] = r;
            tbl_col[pos] = c;
            tbl_val[pos] = val_in;
            tbl_count++;
         end
      end
      res.count = COUNT_W'(tbl_count);
      return res;
   endfunction

   // Pick a key that sorts after the last entry. Column steps are small and row steps
   // rare so the key space above the last entry lasts for the whole run.
   function automatic bit pick_append_key(output logic [COORD_W-1:0] r,
                                          output logic [COORD_W-1:0] c);
      logic [COORD_W-1:0] last_r;
      logic [COORD_W-1:0] last_c;
      r = '0;
      c = '0;
      if (tbl_count == 0) begin
         r = COORD_W'($urandom_range(0, 255));
         c = COORD_W'($urandom);
         return 1'b1;
      end
      last_r = tbl_row[tbl_count-1];
      last_c = tbl_col[tbl_count-1];
      if ($urandom_range(0, 7) != 0 && last_c < 16'hFFC0) begin
         r = last_r;
         c = last_c + COORD_W'($urandom_range(1, 40));
      end else if (last_r != {COORD_W{1'b1}}) begin
         r = last_r + 1'b1;
         c = COORD_W'($urandom);
      end else if (last_c != {COORD_W{1'b1}}) begin
         r = last_r;
         c = last_c + 1'b1;
      end else begin
         return 1'b0;
      end
      return 1'b1;
   endfunction

   // Present one request, hold it until accepted, then record what it must produce.
   // valid stays high between back-to-back transactions; it only drops for a gap.
   task automatic send_request(input logic kind,
                               input logic [COORD_W-1:0] r,
                               input logic [COORD_W-1:0] c,
                               input logic [VALUE_W-1:0] v,
                               input logic [INDEX_W-1:0] idx);
      if (idle_enable && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.kind       <= kind;
      req_chan.row        <= r;
      req_chan.column     <= c;
      req_chan.value      <= v;
      req_chan.read_index <= idx;
      do @(posedge clock); while (!req_chan.ready);
      pending_outcomes.insert(pending_outcomes.size(), update_table(kind, r, c, v, idx));
   endtask

   function automatic logic [VALUE_W-1:0] random_value();
      return {$urandom, $urandom};
   endfunction

   // Empty table: every read is out of range, including the top index.
   task automatic test_empty_reads();
      send_request(KIND_READ, '0, '0, '0, '0);
      send_request(KIND_READ, '1, '1, '1, '1);
   endtask

   // Build a small table that hits each placement path once: appends within a row and
   // into a new row, insert at the very front, inside a row, at the head of a row and
   // as a new row between rows, then overwrites in the middle, at the end and at the front.
   task automatic test_placement_paths();
      send_request(KIND_INSERT, 16'h0040, 16'h0100, '0, '0);
      send_request(KIND_INSERT, 16'h0040, 16'h0200, '1, '0);
      send_request(KIND_INSERT, 16'h0050, 16'h0000, 64'hA5A5_5A5A_F00F_0FF0, '0);
      send_request(KIND_INSERT, 16'h0000, 16'h0000, 64'd1, '0);
      send_request(KIND_INSERT, 16'h0040, 16'h0180, random_value(), '0);
      send_request(KIND_INSERT, 16'h0040, 16'h0080, random_value(), '0);
      send_request(KIND_INSERT, 16'h0045, 16'hFFFF, random_value(), '0);
      send_request(KIND_INSERT, 16'h0040, 16'h0180, 64'h8000_0000_0000_0001, '1);
      send_request(KIND_INSERT, 16'h0050, 16'h0000, random_value(), '0);
      send_request(KIND_INSERT, 16'h0000, 16'h0000, '1, '0);
   endtask

   // Walk the table back, one past the end included.
   task automatic test_read_back();
      int n;
      n = tbl_count;
      for (int i = 0; i <= n; i++)
         send_request(KIND_READ, '0, '0, random_value(), INDEX_W'(i));
   endtask

   // Mostly well-formed traffic on a growing table, with some fully random transactions.
   task automatic test_random_mix();
      logic [COORD_W-1:0] r;
      logic [COORD_W-1:0] c;
      int                 pick;
      int                 e;
      for (int n = 0; n < MIX_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         r    = COORD_W'($urandom);
         c    = COORD_W'($urandom);
         e    = (tbl_count > 0) ? $urandom_range(0, tbl_count - 1) : 0;
         if (pick < 30) begin
            if (!pick_append_key(r, c)) begin
               r = COORD_W'($urandom);
               c = COORD_W'($urandom);
            end
            send_request(KIND_INSERT, r, c, random_value(), INDEX_W'($urandom));
         end else if (pick < 45 || tbl_count == 0) begin
            send_request(KIND_INSERT, r, c, random_value(), INDEX_W'($urandom));
         end else if (pick < 55) begin
            // new column inside a row that already has entries
            send_request(KIND_INSERT, tbl_row[e], c, random_value(), INDEX_W'($urandom));
         end else if (pick < 67) begin
            send_request(KIND_INSERT, tbl_row[e], tbl_col[e], random_value(),
                         INDEX_W'($urandom));
         end else if (pick < 82) begin
            send_request(KIND_READ, r, c, random_value(), INDEX_W'(e));
         end else if (pick < 87) begin
            send_request(KIND_READ, r, c, random_value(),
                         INDEX_W'($urandom_range(tbl_count, 2**INDEX_W - 1)));
         end else begin
            send_request(logic'($urandom_range(0, 1)), r, c, random_value(),
                         INDEX_W'($urandom));
         end
      end
   endtask

   // Append until the table holds its full capacity.
   task automatic test_fill_to_capacity();
      logic [COORD_W-1:0] r;
      logic [COORD_W-1:0] c;
      while (tbl_count < TABLE_DEPTH) begin
         if (!pick_append_key(r, c)) begin
            r = COORD_W'($urandom);
            c = COORD_W'($urandom);
         end
         send_request(KIND_INSERT, r, c, random_value(), INDEX_W'($urandom));
      end
   endtask

   // Full table: new entries are refused on both the append and the insert path,
   // overwrites still land, and the first, last and random indices read back.
   task automatic test_full_table();
      logic [COORD_W-1:0] r;
      logic [COORD_W-1:0] c;
      int                 pick;
      int                 e;
      if (pick_append_key(r, c))
         send_request(KIND_INSERT, r, c, random_value(), '0);
      send_request(KIND_INSERT, tbl_row[0], tbl_col[0] + 1'b1, random_value(), '0);
      send_request(KIND_INSERT, tbl_row[0], tbl_col[0], '1, '0);
      send_request(KIND_INSERT, tbl_row[TABLE_DEPTH-1], tbl_col[TABLE_DEPTH-1], '0, '0);
      send_request(KIND_READ, '0, '0, '0, '0);
      send_request(KIND_READ, '1, '1, '1, '1);
      for (int n = 0; n < FULL_ITEMS; n++) begin
         pick = $urandom_range(0, 9);
         e    = $urandom_range(0, TABLE_DEPTH - 1);
         r    = COORD_W'($urandom);
         c    = COORD_W'($urandom);
         if (pick < 4)
            send_request(KIND_INSERT, tbl_row[e], tbl_col[e], random_value(), '0);
         else if (pick < 6)
            send_request(KIND_INSERT, r, c, random_value(), INDEX_W'($urandom));
         else if (pick < 9)
            send_request(KIND_READ, r, c, random_value(), INDEX_W'(e));
         else if (pick_append_key(r, c))
            send_request(KIND_INSERT, r, c, random_value(), '0);
      end
   endtask

   // Response-side ready: random stall bursts while idling is enabled, else always ready.
   initial begin : drive_rsp_ready
      forever begin
         if (idle_enable && $urandom_range(0, 2) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         repeat ($urandom_range(1, 30)) @(posedge clock);
      end
   end

   // Every response transaction is matched against the oldest outstanding prediction.
   always @(posedge clock) begin : check_outcome
      outcome_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_outcomes.size() == 0) begin
            $error("response with no request outstanding, status %0d", rsp_chan.status);
            fail_count++;
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_chan.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_chan.status);
               fail_count++;
            end
            if (rsp_chan.entry_row !== want.row) begin
               $error("entry_row: expected %h, got %h", want.row, rsp_chan.entry_row);
               fail_count++;
            end
            if (rsp_chan.entry_column !== want.column) begin
               $error("entry_column: expected %h, got %h", want.column,
                      rsp_chan.entry_column);
               fail_count++;
            end
            if (rsp_chan.entry_value !== want.value) begin
               $error("entry_value: expected %h, got %h", want.value,
                      rsp_chan.entry_value);
               fail_count++;
            end
            if (rsp_chan.entry_count !== want.count) begin
               $error("entry_count: expected %0d, got %0d", want.count,
                      rsp_chan.entry_count);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: too long without any transaction on either channel ends the run.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   initial begin
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.kind       <= KIND_INSERT;
      req_chan.row        <= '0;
      req_chan.column     <= '0;
      req_chan.value      <= '0;
      req_chan.read_index <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_empty_reads();
      test_placement_paths();
      test_read_back();
      test_random_mix();
      test_fill_to_capacity();
      // last stretch runs with both sides streaming
      idle_enable = 1'b0;
      test_full_table();
      req_chan.valid <= 1'b0;

      while (pending_outcomes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule

FILE: files.f
design/ssei_pkg.sv
design/ssei_req_if.sv
design/ssei_rsp_if.sv
design/ssei_ram.sv
design/sorted_sparse_entry_insert.sv
tb/tb.sv
